// File: rtl/core/dq_pkg.sv
// ----------------------------------------------------------------------------
// dq_pkg
// Shared widths, operation and status codes and result types of the
// double-ended queue.
// ----------------------------------------------------------------------------
`default_nettype none

package dq_pkg;

   localparam int CAPACITY = 32;
   localparam int IDX_W    = $clog2(CAPACITY);
   localparam int CNT_W    = $clog2(CAPACITY + 1);

   localparam int OP_W     = 3;
   localparam int VALUE_W  = 32;
   localparam int STATUS_W = 2;
   localparam int OCC_W    = 6;

   localparam logic [OP_W-1:0] OP_PUSH_FRONT = 3'd0;
   localparam logic [OP_W-1:0] OP_PUSH_BACK  = 3'd1;
   localparam logic [OP_W-1:0] OP_POP_FRONT  = 3'd2;
   localparam logic [OP_W-1:0] OP_POP_BACK   = 3'd3;
   localparam logic [OP_W-1:0] OP_DUMP       = 3'd4;

   localparam logic [STATUS_W-1:0] STATUS_OK    = 2'd0;
   localparam logic [STATUS_W-1:0] STATUS_FULL  = 2'd1;
   localparam logic [STATUS_W-1:0] STATUS_EMPTY = 2'd2;

   typedef struct packed {
      logic [VALUE_W-1:0]  value;
      logic [STATUS_W-1:0] status;
      logic [OCC_W-1:0]    occupancy;
      logic                last;
   } rsp_payload_type;

   typedef struct packed {
      logic            valid;
      rsp_payload_type data;
   } rsp_stage_type;

endpackage

`default_nettype wire

// File: rtl/core/dq_ram.sv
// ----------------------------------------------------------------------------
// dq_ram
// Generic single-clock RAM, one write port and one read port, read data
// registered.
// ----------------------------------------------------------------------------
`default_nettype none

module dq_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 32
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic                     rd_en,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

// File: rtl/core/dq_ctrl.sv
// ----------------------------------------------------------------------------
// dq_ctrl
// Ring pointer control of the queue: decodes requests, writes pushes into
// the entry RAM, moves front index and count, and sequences dump reads.
// ----------------------------------------------------------------------------
`default_nettype none

module dq_ctrl (
   input  wire logic                         clock,
   input  wire logic                         reset,
   input  wire logic                         req_valid,
   output logic                              req_stall,
   input  wire logic [dq_pkg::OP_W-1:0]      req_operation,
   input  wire logic [dq_pkg::VALUE_W-1:0]   req_value,
   input  wire logic                         slot_free,
   output dq_pkg::rsp_stage_type             stage
);
   import dq_pkg::*;

   localparam logic ST_IDLE = 1'b0;
   localparam logic ST_DUMP = 1'b1;

   logic             state_ff, state_in;
   logic [IDX_W-1:0] front_ff, front_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic [CNT_W-1:0] dump_i_ff, dump_i_in;
   logic [CNT_W-1:0] dump_n_ff, dump_n_in;

   logic                stage_v_ff, stage_v_in;
   logic                stage_ram_ff, stage_ram_in;
   logic [STATUS_W-1:0] stage_status_ff, stage_status_in;
   logic [OCC_W-1:0]    stage_occ_ff, stage_occ_in;
   logic                stage_last_ff, stage_last_in;

   logic               wr_en, rd_en;
   logic [IDX_W-1:0]   wr_addr, rd_addr;
   logic [VALUE_W-1:0] rd_data;

   logic accept, full, empty, dump_final;

   // front + offset, folded back into the ring (sum stays below twice capacity)
   function automatic logic [IDX_W-1:0] ring_idx(input logic [CNT_W:0] s);
      if (s >= (CNT_W+1)'(CAPACITY)) begin
         return IDX_W'(s - (CNT_W+1)'(CAPACITY));
      end
      return IDX_W'(s);
   endfunction

   assign req_stall  = (state_ff != ST_IDLE) || !slot_free;
   assign accept     = req_valid && !req_stall;
   assign full       = (count_ff == CNT_W'(CAPACITY));
   assign empty      = (count_ff == '0);
   assign dump_final = (dump_i_ff == dump_n_ff);

   always_comb begin
      state_in        = state_ff;
      front_in        = front_ff;
      count_in        = count_ff;
      dump_i_in       = dump_i_ff;
      dump_n_in       = dump_n_ff;
      wr_en           = 1'b0;
      wr_addr         = front_ff;
      rd_en           = 1'b0;
      rd_addr         = front_ff;
      stage_v_in      = 1'b0;
      stage_ram_in    = 1'b0;
      stage_status_in = STATUS_OK;
      stage_occ_in    = OCC_W'(count_ff);
      stage_last_in   = 1'b1;

      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               stage_v_in = 1'b1;
               unique case (req_operation)
                  OP_PUSH_FRONT: begin
                     if (full) begin
                        stage_status_in = STATUS_FULL;
                     end else begin
                        front_in     = (front_ff == '0) ? IDX_W'(CAPACITY - 1)
                                                        : front_ff - IDX_W'(1);
                        wr_en        = 1'b1;
                        wr_addr      = front_in;
                        count_in     = count_ff + CNT_W'(1);
                        stage_occ_in = OCC_W'(count_in);
                     end
                  end
                  OP_PUSH_BACK: begin
                     if (full) begin
                        stage_status_in = STATUS_FULL;
                     end else begin
                        wr_en        = 1'b1;
                        wr_addr      = ring_idx((CNT_W+1)'(front_ff)
                                                + (CNT_W+1)'(count_ff));
                        count_in     = count_ff + CNT_W'(1);
                        stage_occ_in = OCC_W'(count_in);
                     end
                  end
                  OP_POP_FRONT: begin
                     if (empty) begin
                        stage_status_in = STATUS_EMPTY;
                     end else begin
                        front_in     = ring_idx((CNT_W+1)'(front_ff) + (CNT_W+1)'(1));
                        count_in     = count_ff - CNT_W'(1);
                        stage_occ_in = OCC_W'(count_in);
                     end
                  end
                  OP_POP_BACK: begin
                     if (empty) begin
                        stage_status_in = STATUS_EMPTY;
                     end else begin
                        count_in     = count_ff - CNT_W'(1);
                        stage_occ_in = OCC_W'(count_in);
                     end
                  end
                  OP_DUMP: begin
                     if (empty) begin
                        stage_status_in = STATUS_EMPTY;
                     end else begin
                        // results come from the read sequence instead
                        stage_v_in = 1'b0;
                        state_in   = ST_DUMP;
                        dump_i_in  = '0;
                        dump_n_in  = count_ff;
                     end
                  end
                  default: begin
                  end
               endcase
            end
         end
         ST_DUMP: begin
            if (slot_free) begin
               stage_v_in    = 1'b1;
               stage_ram_in  = 1'b1;
               rd_en         = 1'b1;
               stage_occ_in  = OCC_W'(dump_n_ff);
               stage_last_in = dump_final;
               // closing result repeats the front entry
               rd_addr       = dump_final ? front_ff
                                          : ring_idx((CNT_W+1)'(front_ff)
                                                     + (CNT_W+1)'(dump_i_ff));
               dump_i_in     = dump_i_ff + CNT_W'(1);
               if (dump_final) begin
                  state_in = ST_IDLE;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= ST_IDLE;
         front_ff   <= '0;
         count_ff   <= '0;
         stage_v_ff <= 1'b0;
      end else begin
         state_ff   <= state_in;
         front_ff   <= front_in;
         count_ff   <= count_in;
         stage_v_ff <= stage_v_in;
      end
   end

   always_ff @(posedge clock) begin
      dump_i_ff       <= dump_i_in;
      dump_n_ff       <= dump_n_in;
      stage_ram_ff    <= stage_ram_in;
      stage_status_ff <= stage_status_in;
      stage_occ_ff    <= stage_occ_in;
      stage_last_ff   <= stage_last_in;
   end

   // a push write lands in the RAM before any dump read can start,
   // so no forwarding path is needed
   dq_ram #(
      .WIDTH (VALUE_W),
      .DEPTH (CAPACITY)
   ) u_entry_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (req_value),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   always_comb begin
      stage.valid          = stage_v_ff;
      stage.data.value     = stage_ram_ff ? rd_data : '0;
      stage.data.status    = stage_status_ff;
      stage.data.occupancy = stage_occ_ff;
      stage.data.last      = stage_last_ff;
   end

endmodule

`default_nettype wire

// File: rtl/core/double_ended_queue.sv
// ----------------------------------------------------------------------------
// double_ended_queue
// Bounded double-ended queue of signed 32-bit values in a ring RAM, with
// push/pop at either end and a front-to-back dump.
//
//   channel   direction  handshake            payload
//   req_      in         req_valid/req_stall  operation, value
//   rsp_      out        rsp_valid/rsp_stall  value_res, status, occupancy, last
//
// Push, pop and unused codes give one result each. A dump of n entries gives
// n + 1 results, one per cycle while the output buffer has room, limited by
// the single RAM read port; no request is taken until its last read is
// issued. Reset clears state, front index, count and valid flags; the entry
// RAM is not cleared. Results pass through a two-entry output buffer, so a
// stalled result does not block the next request.
// ----------------------------------------------------------------------------
`default_nettype none

module double_ended_queue (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire logic                              req_valid,
   output logic                                   req_stall,
   input  wire logic        [dq_pkg::OP_W-1:0]    req_operation,
   input  wire logic signed [dq_pkg::VALUE_W-1:0] req_value,
   output logic                                   rsp_valid,
   input  wire logic                              rsp_stall,
   output logic signed      [dq_pkg::VALUE_W-1:0] rsp_value_res,
   output logic             [dq_pkg::STATUS_W-1:0] rsp_status,
   output logic             [dq_pkg::OCC_W-1:0]   rsp_occupancy,
   output logic                                   rsp_last
);
   import dq_pkg::*;

   localparam logic [1:0] BUF_SLOTS = 2'd2;

   rsp_stage_type   stage;
   logic            slot_free, take;
   logic [1:0]      fill;
   logic            out_v_ff, out_v_in;
   logic            skid_v_ff, skid_v_in;
   rsp_payload_type out_ff, out_in;
   rsp_payload_type skid_ff, skid_in;

   dq_ctrl u_ctrl (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_stall     (req_stall),
      .req_operation (req_operation),
      .req_value     ($unsigned(req_value)),
      .slot_free     (slot_free),
      .stage         (stage)
   );

   assign take = out_v_ff && !rsp_stall;
   // slots held after this edge, counting the result already in flight
   assign fill = 2'(out_v_ff) + 2'(skid_v_ff) + 2'(stage.valid) - 2'(take);
   assign slot_free = (fill < BUF_SLOTS);

   always_comb begin
      out_v_in  = out_v_ff;
      out_in    = out_ff;
      skid_v_in = skid_v_ff;
      skid_in   = skid_ff;
      if (!out_v_ff || take) begin
         if (skid_v_ff) begin
            out_v_in  = 1'b1;
            out_in    = skid_ff;
            skid_v_in = stage.valid;
            skid_in   = stage.data;
         end else begin
            out_v_in = stage.valid;
            out_in   = stage.data;
         end
      end else if (stage.valid) begin
         skid_v_in = 1'b1;
         skid_in   = stage.data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_v_ff  <= 1'b0;
         skid_v_ff <= 1'b0;
      end else begin
         out_v_ff  <= out_v_in;
         skid_v_ff <= skid_v_in;
      end
   end

   always_ff @(posedge clock) begin
      out_ff  <= out_in;
      skid_ff <= skid_in;
   end

   assign rsp_valid     = out_v_ff;
   assign rsp_value_res = $signed(out_ff.value);
   assign rsp_status    = out_ff.status;
   assign rsp_occupancy = out_ff.occupancy;
   assign rsp_last      = out_ff.last;

   a_skid_needs_head: assert property (@(posedge clock) disable iff (reset)
      skid_v_ff |-> out_v_ff)
      else $error("skid entry held while output register is empty");

   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      (stage.valid && skid_v_ff) |-> take)
      else $error("result arrived with output buffer full");

   // a dump of a filled queue starts its read sequence instead
   a_request_yields_result: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall && req_operation != OP_DUMP) |=> stage.valid)
      else $error("accepted request produced no result stage");

   a_occupancy_bound: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_occupancy <= OCC_W'(CAPACITY)))
      else $error("occupancy above capacity");

endmodule

`default_nettype wire

// File: tb/sv/dq_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// dq_checker
// Watches the request and result channels of the double-ended queue, keeps
// its own ring model of the queue, works out the results of every accepted
// request and compares each accepted result with the oldest one outstanding.
// ----------------------------------------------------------------------------

module dq_checker (
   input  wire logic                                     clock,
   input  wire logic                                     reset,
   input  wire logic                                     req_valid,
   input  wire logic                                     req_stall,
   input  wire logic        [dq_pkg::OP_W-1:0]           req_operation,
   input  wire logic signed [dq_pkg::VALUE_W-1:0]        req_value,
   input  wire logic                                     rsp_valid,
   input  wire logic                                     rsp_stall,
   input  wire logic signed [dq_pkg::VALUE_W-1:0]        rsp_value_res,
   input  wire logic        [dq_pkg::STATUS_W-1:0]       rsp_status,
   input  wire logic        [dq_pkg::OCC_W-1:0]          rsp_occupancy,
   input  wire logic                                     rsp_last,
   output int unsigned                                   mismatch_count,
   output int unsigned                                   pending_count
);

   import dq_pkg::*;

   logic [VALUE_W-1:0] model_ring [CAPACITY];
   int                 model_head;
   int                 model_count;
   rsp_payload_type    awaited_results [$];

   task automatic report_mismatch(input string what);
      mismatch_count++;
      if (mismatch_count <= 50) begin
         $display("%0t ns  mismatch: %s", $time, what);
      end
   endtask

   task automatic add_result(input logic [VALUE_W-1:0] val, input logic [STATUS_W-1:0] st,
                             input int occ, input logic lst);
      rsp_payload_type item;
      item.value     = val;
      item.status    = st;
      item.occupancy = OCC_W'(occ);
      item.last      = lst;
      awaited_results.push_back(item);
   endtask

   task automatic apply_request(input logic [OP_W-1:0] op, input logic [VALUE_W-1:0] val);
      int n;
      n = model_count;
      case (op)
         OP_PUSH_FRONT, OP_PUSH_BACK: begin
            if (n >= CAPACITY) begin
               add_result('0, STATUS_FULL, n, 1'b1);
            end else begin
               if (op == OP_PUSH_FRONT) begin
                  model_head = (model_head + CAPACITY - 1) % CAPACITY;
                  model_ring[model_head] = val;
               end else begin
                  model_ring[(model_head + n) % CAPACITY] = val;
               end
               model_count = n + 1;
               add_result('0, STATUS_OK, n + 1, 1'b1);
            end
         end
         OP_POP_FRONT, OP_POP_BACK: begin
            if (n == 0) begin
               add_result('0, STATUS_EMPTY, 0, 1'b1);
            end else begin
               if (op == OP_POP_FRONT) begin
                  model_head = (model_head + 1) % CAPACITY;
               end
               model_count = n - 1;
               add_result('0, STATUS_OK, n - 1, 1'b1);
            end
         end
         OP_DUMP: begin
            if (n == 0) begin
               add_result('0, STATUS_EMPTY, 0, 1'b1);
            end else begin
               for (int i = 0; i < n; i++) begin
                  add_result(model_ring[(model_head + i) % CAPACITY], STATUS_OK, n, 1'b0);
               end
               // the front value comes once more, closing the dump
               add_result(model_ring[model_head], STATUS_OK, n, 1'b1);
            end
         end
         default: begin
            add_result('0, STATUS_OK, n, 1'b1);
         end
      endcase
   endtask

   task automatic check_result();
      rsp_payload_type want;
      if (awaited_results.size() == 0) begin
         report_mismatch($sformatf("result with none outstanding: value %0d status %0d occ %0d last %0d",
                                   rsp_value_res, rsp_status, rsp_occupancy, rsp_last));
         return;
      end
      want = awaited_results.pop_front();
      if (rsp_value_res !== want.value || rsp_status !== want.status ||
          rsp_occupancy !== want.occupancy || rsp_last !== want.last) begin
         report_mismatch($sformatf("got/exp value %0d/%0d status %0d/%0d occ %0d/%0d last %0d/%0d",
                                   rsp_value_res, $signed(want.value), rsp_status, want.status,
                                   rsp_occupancy, want.occupancy, rsp_last, want.last));
      end
   endtask

   always @(posedge clock) begin
      if (reset) begin
         model_head  = 0;
         model_count = 0;
         awaited_results.delete();
      end else begin
         if (req_valid && !req_stall) begin
            apply_request(req_operation, req_value);
         end
         if (rsp_valid && !rsp_stall) begin
            check_result();
         end
      end
      pending_count <= awaited_results.size();
   end

endmodule

// File: tb/sv/tb_top.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Drives the double-ended queue with a short directed sequence followed by
// random fill, drain and mixed phases, with bursty requests and a changing
// result stall pattern; the checker beside the block does the comparing.
// ----------------------------------------------------------------------------

module tb_top;

   import dq_pkg::*;

   localparam int RANDOM_REQUESTS = 480;
   localparam int DRAIN_LIMIT     = 20000;
   localparam int SETTLE_CYCLES   = 16;

   logic                         clock = 1'b0;
   logic                         reset = 1'b1;
   logic                         req_valid = 1'b0;
   logic        [OP_W-1:0]       req_operation = OP_PUSH_FRONT;
   logic signed [VALUE_W-1:0]    req_value = '0;
   logic                         rsp_stall = 1'b0;
   logic                         req_stall;
   logic                         rsp_valid;
   logic signed [VALUE_W-1:0]    rsp_value_res;
   logic        [STATUS_W-1:0]   rsp_status;
   logic        [OCC_W-1:0]      rsp_occupancy;
   logic                         rsp_last;
   int unsigned                  mismatch_count;
   int unsigned                  pending_count;
   int unsigned                  requests_sent = 0;
   int unsigned                  burst_left = 0;

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   double_ended_queue DUT (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_stall     (req_stall),
      .req_operation (req_operation),
      .req_value     (req_value),
      .rsp_valid     (rsp_valid),
      .rsp_stall     (rsp_stall),
      .rsp_value_res (rsp_value_res),
      .rsp_status    (rsp_status),
      .rsp_occupancy (rsp_occupancy),
      .rsp_last      (rsp_last)
   );

   dq_checker u_checker (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_operation  (req_operation),
      .req_value      (req_value),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_value_res  (rsp_value_res),
      .rsp_status     (rsp_status),
      .rsp_occupancy  (rsp_occupancy),
      .rsp_last       (rsp_last),
      .mismatch_count (mismatch_count),
      .pending_count  (pending_count)
   );

   // called at a falling edge; may drop valid for a gap between bursts
   task automatic pace_sender();
      int unsigned gap;
      if (burst_left == 0) begin
         burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(30, 80) : $urandom_range(1, 12);
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
         if (gap != 0) begin
            req_valid <= 1'b0;
            repeat (gap) @(negedge clock);
         end
      end
      burst_left--;
   endtask

   task automatic send_request(input logic [OP_W-1:0] op, input logic [VALUE_W-1:0] val);
      pace_sender();
      req_valid     <= 1'b1;
      req_operation <= op;
      req_value     <= val;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      @(negedge clock);
      requests_sent++;
   endtask

   function automatic logic [VALUE_W-1:0] pick_value();
      case ($urandom_range(0, 9))
         0:       return 32'h7FFF_FFFF;
         1:       return 32'h8000_0000;
         2:       return '0;
         3:       return '1;
         default: return $urandom;
      endcase
   endfunction

   function automatic logic [OP_W-1:0] pick_push();
      return ($urandom_range(0, 1) == 0) ? OP_PUSH_FRONT : OP_PUSH_BACK;
   endfunction

   function automatic logic [OP_W-1:0] pick_pop();
      return ($urandom_range(0, 1) == 0) ? OP_POP_FRONT : OP_POP_BACK;
   endfunction

   function automatic logic [OP_W-1:0] pick_operation();
      int unsigned r;
      r = $urandom_range(0, 99);
      if (r < 44) return pick_push();
      if (r < 76) return pick_pop();
      if (r < 94) return OP_DUMP;
      return OP_W'($urandom_range(int'(OP_DUMP) + 1, (1 << OP_W) - 1));
   endfunction

   // pushes past capacity from any level, then a dump of the full queue
   task automatic fill_queue();
      repeat ($urandom_range(CAPACITY + 2, CAPACITY + 6)) send_request(pick_push(), pick_value());
      send_request(OP_DUMP, pick_value());
   endtask

   task automatic drain_queue();
      repeat ($urandom_range(CAPACITY + 1, CAPACITY + 4)) send_request(pick_pop(), pick_value());
      send_request(OP_DUMP, pick_value());
   endtask

   initial begin : result_stall
      int unsigned mode;
      int unsigned span;
      int unsigned run;
      run = 0;
      forever begin
         mode = $urandom_range(0, 3);
         span = $urandom_range(20, 200);
         repeat (span) begin
            @(negedge clock);
            case (mode)
               0: rsp_stall <= 1'b0;
               1: rsp_stall <= ($urandom_range(0, 3) == 0);
               2: rsp_stall <= ($urandom_range(0, 3) != 0);
               default: begin
                  // long runs of stall and of flow
                  if (run == 0) begin
                     rsp_stall <= ~rsp_stall;
                     run = $urandom_range(1, 12);
                  end
                  run--;
               end
            endcase
         end
      end
   end

   initial begin : stimulus
      int unsigned waited;
      int unsigned target;
      repeat (4) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // empty queue: pops and dump flag empty, unused codes do nothing
      send_request(OP_POP_FRONT, 32'h1234_5678);
      send_request(OP_POP_BACK, '1);
      send_request(OP_DUMP, '0);
      for (int op = int'(OP_DUMP) + 1; op < (1 << OP_W); op++) begin
         send_request(OP_W'(op), 32'hDEAD_BEEF);
      end
      send_request(OP_PUSH_FRONT, 32'h7FFF_FFFF);
      send_request(OP_PUSH_BACK, 32'h8000_0000);
      send_request(OP_PUSH_FRONT, '1);
      send_request(OP_PUSH_BACK, '0);
      send_request(OP_PUSH_FRONT, 32'h5555_5555);
      send_request(OP_PUSH_BACK, 32'hAAAA_AAAA);
      send_request(OP_DUMP, '1);
      send_request(OP_POP_FRONT, '0);
      send_request(OP_POP_BACK, '0);
      send_request(OP_W'((1 << OP_W) - 1), '0);
      send_request(OP_DUMP, '0);
      repeat (4) send_request(OP_POP_FRONT, '0);
      send_request(OP_DUMP, '0);

      // full queue and the longest dump come first, then random phases
      target = requests_sent + RANDOM_REQUESTS;
      fill_queue();
      drain_queue();
      while (requests_sent < target) begin
         case ($urandom_range(0, 5))
            0:       fill_queue();
            1:       drain_queue();
            default: repeat ($urandom_range(10, 40)) send_request(pick_operation(), pick_value());
         endcase
      end
      req_valid <= 1'b0;

      waited = 0;
      while (pending_count != 0 && waited < DRAIN_LIMIT) begin
         @(posedge clock);
         waited++;
      end
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (mismatch_count == 0 && pending_count == 0) begin
         $display("[double_ended_queue] OK");
      end else begin
         $display("[double_ended_queue] ERROR");
      end
      $finish;
   end

   initial begin : run_limit
      #4_000_000;
      $display("[double_ended_queue] ERROR");
      $finish;
   end

endmodule
